### design/ceo_pkg.sv
package ceo_pkg;
    localparam int SLOTS = 16;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] MODE_ENQ    = 2'd0;
    localparam logic [1:0] MODE_TAKE   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;
    localparam logic [2:0] ST_BAD_SLOT = 3'd5;

    localparam logic [15:0] TEXT_LIMIT_RST = 16'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_WRITE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] key_code;
        logic [31:0] payload_handle;
        logic [15:0] text_length;
        logic [3:0]  done_slot;
        logic [15:0] send_code;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [31:0] out_payload;
        logic [4:0]  pending_count;
        logic [4:0]  high_water;
        logic [31:0] accepted_count;
        logic [31:0] coalesced_count;
        logic [31:0] overflow_count;
        logic [31:0] delivered_count;
        logic [31:0] send_error_count;
        logic [15:0] last_send_code;
    } out_item_t;
endpackage

### design/ceo_if.sv
interface ceo_in_if import ceo_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ceo_out_if import ceo_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### design/coalescing_event_outbox_core.sv
// Channel   Dir  Handshake    Payload
// in_ch     in   valid/ready  mode, key_code, payload_handle, text_length, done_slot, send_code
// out_ch    out  valid/ready  status, slot_index, out_payload, statistics
// cfg       in   cfg_we       cfg_wdata -> text_limit
//
// One transaction at a time: a scan over all slots (one registered memory read per
// cycle), then a finish state and a write-back state; the result is then held in S_OUT
// and the next transaction is accepted only after out_ch has taken it. The single
// memory read port is why the slots are scanned one after another.
// Reset clears control, flags and statistics; slot data memory is not cleared.
// The result waits in its register while out_ch stalls; no new input then.
module coalescing_event_outbox_core
    import ceo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    ceo_in_if.sink      in_ch,
    ceo_out_if.source   out_ch
);
    // slot memory: ticket, key, payload
    logic [79:0] mem [SLOTS];
    logic [79:0] rd_q;

    // per-slot flags in flops (reset to zero)
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] sending_reg, sending_next;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [15:0] limit_reg;
    logic [CW-1:0] ptr_reg, ptr_next;   // read address counter
    logic [SW-1:0] rd_idx_reg;          // index of entry in rd_q
    logic rd_vld_reg, rd_vld_next;

    // scan results
    logic match_reg, match_next;
    logic [SW-1:0] match_idx_reg, match_idx_next;
    logic best_reg, best_next;
    logic [SW-1:0] best_idx_reg, best_idx_next;
    logic [31:0] best_tk_reg, best_tk_next;
    logic [31:0] best_pl_reg, best_pl_next;

    logic [31:0] ticket_reg, ticket_next;
    logic [CW-1:0] pend_reg, pend_next, peak_reg, peak_next;
    logic [31:0] acc_reg, acc_next, coal_reg, coal_next, ovf_reg, ovf_next;
    logic [31:0] dlv_reg, dlv_next, fail_reg, fail_next;
    logic [15:0] lcode_reg, lcode_next;

    // write-back request
    logic we_reg, we_next;
    logic [SW-1:0] wa_reg, wa_next;
    logic [79:0] wd_reg, wd_next;

    out_item_t res_reg, res_next;
    logic first_free_vld;
    logic [SW-1:0] first_free;
    logic [SW-1:0] ds;
    logic ds_ok;

    always_ff @(posedge clk)
    begin
        if (we_reg)
        begin
            mem[wa_reg] <= wd_reg;
        end
        rd_q <= mem[ptr_reg[SW-1:0]];
        rd_idx_reg <= ptr_reg[SW-1:0];
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= in_ch.payload;
        end
        wa_reg <= wa_next;
        wd_reg <= wd_next;
        match_idx_reg <= match_idx_next;
        best_idx_reg <= best_idx_next;
        best_tk_reg <= best_tk_next;
        best_pl_reg <= best_pl_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= TEXT_LIMIT_RST;
            used_reg <= '0;
            sending_reg <= '0;
            ptr_reg <= '0;
            rd_vld_reg <= 1'b0;
            match_reg <= 1'b0;
            best_reg <= 1'b0;
            ticket_reg <= '0;
            pend_reg <= '0;
            peak_reg <= '0;
            acc_reg <= '0;
            coal_reg <= '0;
            ovf_reg <= '0;
            dlv_reg <= '0;
            fail_reg <= '0;
            lcode_reg <= '0;
            we_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            used_reg <= used_next;
            sending_reg <= sending_next;
            ptr_reg <= ptr_next;
            rd_vld_reg <= rd_vld_next;
            match_reg <= match_next;
            best_reg <= best_next;
            ticket_reg <= ticket_next;
            pend_reg <= pend_next;
            peak_reg <= peak_next;
            acc_reg <= acc_next;
            coal_reg <= coal_next;
            ovf_reg <= ovf_next;
            dlv_reg <= dlv_next;
            fail_reg <= fail_next;
            lcode_reg <= lcode_next;
            we_reg <= we_next;
        end
    end

    // lowest free slot from the flag flops
    always_comb
    begin
        first_free_vld = 1'b0;
        first_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                first_free_vld = 1'b1;
                first_free = SW'(i);
            end
        end
    end

    assign ds = item_reg.done_slot[SW-1:0];
    assign ds_ok = ({{(32-4){1'b0}}, item_reg.done_slot} < 32'(SLOTS))
        && used_reg[ds] && sending_reg[ds];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!rd_vld_next && rd_vld_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: state_next = S_WRITE;
            S_WRITE: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        ptr_next = ptr_reg;
        rd_vld_next = rd_vld_reg;
        match_next = match_reg;
        match_idx_next = match_idx_reg;
        best_next = best_reg;
        best_idx_next = best_idx_reg;
        best_tk_next = best_tk_reg;
        best_pl_next = best_pl_reg;
        used_next = used_reg;
        sending_next = sending_reg;
        ticket_next = ticket_reg;
        pend_next = pend_reg;
        peak_next = peak_reg;
        acc_next = acc_reg;
        coal_next = coal_reg;
        ovf_next = ovf_reg;
        dlv_next = dlv_reg;
        fail_next = fail_reg;
        lcode_next = lcode_reg;
        we_next = 1'b0;
        wa_next = wa_reg;
        wd_next = wd_reg;
        res_next = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                ptr_next = '0;
                rd_vld_next = 1'b0;
                match_next = 1'b0;
                best_next = 1'b0;
            end
            S_SCAN:
            begin
                // issue reads 0..SLOTS-1, evaluate each in the cycle after its read
                if (ptr_reg < CW'(SLOTS))
                begin
                    ptr_next = ptr_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                if (rd_vld_reg && used_reg[rd_idx_reg] && !sending_reg[rd_idx_reg])
                begin
                    if (!match_reg && rd_q[47:32] == item_reg.key_code)
                    begin
                        match_next = 1'b1;
                        match_idx_next = rd_idx_reg;
                    end
                    if (!best_reg || ((rd_q[79:48] - best_tk_reg) >> 31) != 32'd0)
                    begin
                        best_next = 1'b1;
                        best_idx_next = rd_idx_reg;
                        best_tk_next = rd_q[79:48];
                        best_pl_next = rd_q[31:0];
                    end
                end
            end
            S_FINISH:
            begin
                res_next.status = ST_OK;
                res_next.slot_index = '0;
                res_next.out_payload = '0;
                case (item_reg.mode)
                    MODE_ENQ:
                    begin
                        if (item_reg.text_length == 16'd0)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else if (item_reg.text_length >= limit_reg)
                        begin
                            res_next.status = ST_TOO_LONG;
                        end
                        else if (item_reg.key_code != 16'd0 && match_reg)
                        begin
                            ticket_next = ticket_reg + 1'b1;
                            coal_next = coal_reg + 1'b1;
                            we_next = 1'b1;
                            wa_next = match_idx_reg;
                            wd_next = {ticket_reg + 32'd1, item_reg.key_code,
                                item_reg.payload_handle};
                            res_next.slot_index = 4'(match_idx_reg);
                        end
                        else if (first_free_vld)
                        begin
                            ticket_next = ticket_reg + 1'b1;
                            acc_next = acc_reg + 1'b1;
                            pend_next = pend_reg + 1'b1;
                            if (pend_reg + 1'b1 > peak_reg)
                            begin
                                peak_next = pend_reg + 1'b1;
                            end
                            used_next[first_free] = 1'b1;
                            sending_next[first_free] = 1'b0;
                            we_next = 1'b1;
                            wa_next = first_free;
                            wd_next = {ticket_reg + 32'd1, item_reg.key_code,
                                item_reg.payload_handle};
                            res_next.slot_index = 4'(first_free);
                        end
                        else
                        begin
                            ovf_next = ovf_reg + 1'b1;
                            res_next.status = ST_FULL;
                        end
                    end
                    MODE_TAKE:
                    begin
                        if (best_reg)
                        begin
                            sending_next[best_idx_reg] = 1'b1;
                            res_next.slot_index = 4'(best_idx_reg);
                            res_next.out_payload = best_pl_reg;
                        end
                        else
                        begin
                            res_next.status = ST_NONE;
                        end
                    end
                    MODE_REPORT:
                    begin
                        if (!ds_ok)
                        begin
                            res_next.status = ST_BAD_SLOT;
                        end
                        else
                        begin
                            lcode_next = item_reg.send_code;
                            sending_next[ds] = 1'b0;
                            res_next.slot_index = item_reg.done_slot;
                            if (item_reg.send_code == 16'd0)
                            begin
                                used_next[ds] = 1'b0;
                                dlv_next = dlv_reg + 1'b1;
                                pend_next = pend_reg - 1'b1;
                            end
                            else
                            begin
                                fail_next = fail_reg + 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_WRITE:
            begin
                res_next.pending_count = 5'(pend_reg);
                res_next.high_water = 5'(peak_reg);
                res_next.accepted_count = acc_reg;
                res_next.coalesced_count = coal_reg;
                res_next.overflow_count = ovf_reg;
                res_next.delivered_count = dlv_reg;
                res_next.send_error_count = fail_reg;
                res_next.last_send_code = lcode_reg;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready = (state_reg == S_IDLE);
        out_ch.valid = (state_reg == S_OUT);
        out_ch.payload = res_reg;
    end
endmodule
